FILE: rtl/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants for the push potential argmax block: command and
// status bundles between controller and datapath, codes and fixed values.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

    localparam int JOINT_COUNT = 10;
    localparam int PUSH_WEIGHT = 12;
    localparam int PUSH_FIRST  = 5;
    localparam int PUSH_LAST   = 7;
    localparam int ROOT_STEPS  = 33;

    localparam int IN_W  = 232;
    localparam int OUT_W = 120;
    localparam int SUM_W = 48;

    localparam logic [SUM_W-1:0] BEST_RESET = 48'(-64'sd6553600000);
    localparam logic [SUM_W-1:0] SUM_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN    = 48'h8000_0000_0000;

    // push axis codes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_X   = 2'd1;
    localparam logic [1:0] MODE_Y   = 2'd2;
    localparam logic [1:0] MODE_Z   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_CONTACT_X = 2'd1;
    localparam logic [1:0] REG_CONTACT_Y = 2'd2;
    localparam logic [1:0] REG_CONTACT_Z = 2'd3;

    // multiplier operand selects
    localparam logic [2:0] MUL_PUSH = 3'd0;
    localparam logic [2:0] MUL_SQX  = 3'd1;
    localparam logic [2:0] MUL_SQY  = 3'd2;
    localparam logic [2:0] MUL_SQZ  = 3'd3;
    localparam logic [2:0] MUL_DIST = 3'd4;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       mul_en;
        logic [2:0] mul_op;
        logic       ssq_first;
        logic       ssq_add;
        logic       root_init;
        logic       root_step;
        logic       push_term;
        logic       rest_term;
        logic       acc;
        logic       best;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic joint_ok;
        logic is_push;
        logic is_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer for one joint word: operand prep, shared multiplier passes,
// iterative square root, accumulate, best update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  ppa_pkg::t_stat i_stat,
    output ppa_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_PMUL  = 4'd2;
    localparam logic [3:0] S_PWT   = 4'd3;
    localparam logic [3:0] S_SQX   = 4'd4;
    localparam logic [3:0] S_SQY   = 4'd5;
    localparam logic [3:0] S_SQZ   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_ROOT  = 4'd8;
    localparam logic [3:0] S_DMUL  = 4'd9;
    localparam logic [3:0] S_RTERM = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_BEST  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.joint_ok) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = i_stat.is_push ? S_PMUL : S_SQX;
                end
            end
            S_PMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ppa_pkg::MUL_PUSH;
                n_state      = S_PWT;
            end
            S_PWT: begin
                o_cmd.push_term = 1'b1;
                n_state         = S_ACC;
            end
            S_SQX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ppa_pkg::MUL_SQX;
                n_state      = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_op    = ppa_pkg::MUL_SQY;
                o_cmd.ssq_first = 1'b1;
                n_state         = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_op  = ppa_pkg::MUL_SQZ;
                o_cmd.ssq_add = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.ssq_add   = 1'b1;
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 6'd1;
                if (r_cnt == 6'(ppa_pkg::ROOT_STEPS - 1)) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ppa_pkg::MUL_DIST;
                n_state      = S_RTERM;
            end
            S_RTERM: begin
                o_cmd.rest_term = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.is_last ? S_BEST : S_IDLE;
            end
            S_BEST: begin
                o_cmd.best = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ppa_dp.sv
// ----------------------------------------------------------------------------
// ppa_dp
// Datapath: word registers, shared 33x33 multiplier, bit-pair square root,
// saturating node accumulator, running best and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ppa_pkg::t_cmd                i_cmd,
    output ppa_pkg::t_stat               o_stat,
    input  wire [ppa_pkg::IN_W-1:0]      i_in_data,
    input  wire                          i_in_user,
    input  wire                          i_in_last,
    input  wire [1:0]                    i_mode,
    input  wire [31:0]                   i_contact_x,
    input  wire [31:0]                   i_contact_y,
    input  wire [31:0]                   i_contact_z,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [ppa_pkg::OUT_W-1:0]    o_out_data,
    output logic                         o_out_last
);

    function automatic logic [31:0] f_mag(input logic [32:0] d);
        logic [32:0] n;
        n = ~d + 33'd1;
        return d[32] ? n[31:0] : d[31:0];
    endfunction

    // latched word
    logic [11:0] r_node;
    logic [3:0]  r_joint;
    logic [31:0] r_com_x, r_com_y, r_com_z;
    logic [31:0] r_rest_x, r_rest_y, r_rest_z;
    logic [23:0] r_mass;
    logic        r_start, r_last;

    // prepared operands
    logic [31:0] r_mx, r_my, r_mz, r_pmag;
    logic        r_pneg, r_pzero;

    logic [65:0] r_prod;
    logic [65:0] r_ssq;
    logic [33:0] r_rem;
    logic [32:0] r_root;
    logic [49:0] r_term;

    logic [47:0] r_nsum, r_best;
    logic [11:0] r_best_node;

    logic        r_ovalid;
    logic [11:0] r_o_node;
    logic [47:0] r_o_pot, r_o_best;
    logic [11:0] r_o_best_node;
    logic        r_o_last;

    logic [32:0] w_dx, w_dy, w_dz, w_pd;
    logic [32:0] w_ma, w_mb;
    logic [35:0] w_rem2, w_trial;
    logic [47:0] w_pw;
    logic [49:0] w_sum;
    logic [47:0] w_sat;

    assign o_stat.joint_ok = ({1'b0, r_joint} < 5'(ppa_pkg::JOINT_COUNT));
    assign o_stat.is_push  = ({1'b0, r_joint} >= 5'(ppa_pkg::PUSH_FIRST))
                          && ({1'b0, r_joint} <= 5'(ppa_pkg::PUSH_LAST));
    assign o_stat.is_last  = ({1'b0, r_joint} == 5'(ppa_pkg::JOINT_COUNT - 1));
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign w_dx = {r_rest_x[31], r_rest_x} - {r_com_x[31], r_com_x};
    assign w_dy = {r_rest_y[31], r_rest_y} - {r_com_y[31], r_com_y};
    assign w_dz = {r_rest_z[31], r_rest_z} - {r_com_z[31], r_com_z};

    always_comb begin
        unique case (i_mode)
            ppa_pkg::MODE_X: w_pd = {r_com_x[31], r_com_x} - {i_contact_x[31], i_contact_x};
            ppa_pkg::MODE_Y: w_pd = {r_com_y[31], r_com_y} - {i_contact_y[31], i_contact_y};
            ppa_pkg::MODE_Z: w_pd = {r_com_z[31], r_com_z} - {i_contact_z[31], i_contact_z};
            default:         w_pd = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.mul_op)
            ppa_pkg::MUL_PUSH: begin
                w_ma = {1'b0, r_pmag};
                w_mb = {9'd0, r_mass};
            end
            ppa_pkg::MUL_SQX: begin
                w_ma = {1'b0, r_mx};
                w_mb = {1'b0, r_mx};
            end
            ppa_pkg::MUL_SQY: begin
                w_ma = {1'b0, r_my};
                w_mb = {1'b0, r_my};
            end
            ppa_pkg::MUL_SQZ: begin
                w_ma = {1'b0, r_mz};
                w_mb = {1'b0, r_mz};
            end
            ppa_pkg::MUL_DIST: begin
                w_ma = r_root;
                w_mb = {9'd0, r_mass};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // one bit of root per step, two radicand bits shifted in from the top
    assign w_rem2  = {r_rem, r_ssq[65:64]};
    assign w_trial = {1'b0, r_root, 2'b01};

    assign w_pw = {8'd0, r_prod[55:16]} * {40'd0, 8'(ppa_pkg::PUSH_WEIGHT)};

    assign w_sum = {{2{r_nsum[47]}}, r_nsum} + r_term;
    always_comb begin
        if (w_sum[49:47] == 3'b000 || w_sum[49:47] == 3'b111) begin
            w_sat = w_sum[47:0];
        end else begin
            w_sat = w_sum[49] ? ppa_pkg::SUM_MIN : ppa_pkg::SUM_MAX;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_node   <= i_in_data[11:0];
            r_joint  <= i_in_data[15:12];
            r_com_x  <= i_in_data[47:16];
            r_com_y  <= i_in_data[79:48];
            r_com_z  <= i_in_data[111:80];
            r_rest_x <= i_in_data[143:112];
            r_rest_y <= i_in_data[175:144];
            r_rest_z <= i_in_data[207:176];
            r_mass   <= i_in_data[231:208];
            r_start  <= i_in_user;
            r_last   <= i_in_last;
        end
        if (i_cmd.prep) begin
            r_mx    <= f_mag(w_dx);
            r_my    <= f_mag(w_dy);
            r_mz    <= f_mag(w_dz);
            r_pmag  <= f_mag(w_pd);
            r_pneg  <= w_pd[32] ^ (i_mode == ppa_pkg::MODE_Y);
            r_pzero <= (i_mode == ppa_pkg::MODE_OFF);
        end
        if (i_cmd.mul_en) begin
            r_prod <= 66'(w_ma * w_mb);
        end
        if (i_cmd.ssq_first) begin
            r_ssq <= {2'b00, r_prod[63:0]};
        end else if (i_cmd.ssq_add) begin
            r_ssq <= r_ssq + {2'b00, r_prod[63:0]};
        end else if (i_cmd.root_step) begin
            r_ssq <= {r_ssq[63:0], 2'b00};
        end
        if (i_cmd.root_init) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            if (w_rem2 >= w_trial) begin
                r_rem  <= 34'(w_rem2 - w_trial);
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[33:0];
                r_root <= {r_root[31:0], 1'b0};
            end
        end
        if (i_cmd.push_term) begin
            if (r_pzero) begin
                r_term <= '0;
            end else if (r_pneg) begin
                r_term <= 50'd0 - {2'b00, w_pw};
            end else begin
                r_term <= {2'b00, w_pw};
            end
        end else if (i_cmd.rest_term) begin
            r_term <= 50'd0 - {9'd0, r_prod[56:16]};
        end
        if (i_cmd.out_load) begin
            r_o_node      <= r_node;
            r_o_pot       <= r_nsum;
            r_o_best_node <= r_best_node;
            r_o_best      <= r_best;
            r_o_last      <= r_last;
        end
    end

    // scoring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsum      <= '0;
            r_best      <= ppa_pkg::BEST_RESET;
            r_best_node <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.prep && r_start) begin
                r_nsum      <= '0;
                r_best      <= ppa_pkg::BEST_RESET;
                r_best_node <= '0;
            end
            if (i_cmd.acc) begin
                r_nsum <= w_sat;
            end
            if (i_cmd.best && ($signed(r_nsum) > $signed(r_best))) begin
                r_best      <= r_nsum;
                r_best_node <= r_node;
            end
            if (i_cmd.out_load) begin
                r_nsum   <= '0;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {r_o_best, r_o_best_node, r_o_pot, r_o_node};
    assign o_out_last  = r_o_last;

endmodule

`default_nettype wire

FILE: rtl/push_potential_argmax.sv
// ----------------------------------------------------------------------------
// push_potential_argmax
// Scores candidate postures joint by joint and tracks the best-scoring node.
// ----------------------------------------------------------------------------
// One joint word is taken at a time. A push joint (5 to 7) is folded into the
// node sum after the shared multiplier pass and the weight multiply, and the
// next word is taken only after that. Any other joint is folded in after three
// passes of the shared multiplier for the squares, the 33-step bit-pair square
// root of the squared distance and one pass for the mass product. The last
// joint of a node adds the best update and the hand-off into the output
// register, and the hand-off waits while an earlier result still sits there;
// the output register then lets the next word in while the result waits. A
// word whose joint number is out of range is dropped. Registers must be written
// over the configuration port only while no word is in flight; the user is
// bound to this, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module push_potential_argmax (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // apb
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [3:0]                  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input stream
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // node_index, joint_index, com_x, com_y, com_z, rest_x, rest_y, rest_z,
    // joint_mass
    input  wire [ppa_pkg::IN_W-1:0]    s_axis_tdata,
    // start_scan
    input  wire                        s_axis_tuser,
    // last_node
    input  wire                        s_axis_tlast,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // scored_node, node_potential, best_index, best_potential
    output logic [ppa_pkg::OUT_W-1:0]  m_axis_tdata,
    // scan_done
    output logic                       m_axis_tlast
);

    logic [1:0]  r_mode;
    logic [31:0] r_contact_x, r_contact_y, r_contact_z;
    logic        w_wr;

    ppa_pkg::t_cmd  w_cmd;
    ppa_pkg::t_stat w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ppa_pkg::MODE_X;
            r_contact_x <= '0;
            r_contact_y <= '0;
            r_contact_z <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                ppa_pkg::REG_MODE:      r_mode      <= pwdata[1:0];
                ppa_pkg::REG_CONTACT_X: r_contact_x <= pwdata;
                ppa_pkg::REG_CONTACT_Y: r_contact_y <= pwdata;
                ppa_pkg::REG_CONTACT_Z: r_contact_z <= pwdata;
                default:                r_mode      <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ppa_pkg::REG_MODE:      prdata = {30'd0, r_mode};
            ppa_pkg::REG_CONTACT_X: prdata = r_contact_x;
            ppa_pkg::REG_CONTACT_Y: prdata = r_contact_y;
            ppa_pkg::REG_CONTACT_Z: prdata = r_contact_z;
            default:                prdata = '0;
        endcase
    end

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ppa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_mode      (r_mode),
        .i_contact_x (r_contact_x),
        .i_contact_y (r_contact_y),
        .i_contact_z (r_contact_z),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/ppa_chk.sv
// ----------------------------------------------------------------------------
// ppa_chk
// Port-level checks for push_potential_argmax, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_chk (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [ppa_pkg::OUT_W-1:0]   m_axis_tdata,
    input wire                        m_axis_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    // best never below the node just reported
    a_best_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[119:72]) >= $signed(m_axis_tdata[59:12]))
        else $error("best potential below reported node potential");

endmodule

bind push_potential_argmax ppa_chk u_ppa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/tb_push_potential_argmax.sv
// ----------------------------------------------------------------------------
// tb_push_potential_argmax
// Streams joint words into the push potential argmax block and checks every
// node score word against a predictor of the fixed-point scoring, the square
// root and the running best. Both stream sides idle at random, the push axis
// and contact point are rewritten between phases, and long push runs drive the
// node sum into saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_push_potential_argmax;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     PHASE_WORDS    = 160;
    localparam longint BEST_FLOOR     = -64'sd6553600000;
    localparam longint SUM_TOP        = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_BOTTOM     = -64'sh8000_0000_0000;

    typedef struct {
        logic [11:0]        node;
        logic [3:0]         joint;
        logic signed [31:0] com_x;
        logic signed [31:0] com_y;
        logic signed [31:0] com_z;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] rest_z;
        logic [23:0]        mass;
        logic               start;
        logic               last;
    } t_joint_word;

    typedef struct {
        logic [11:0] node;
        logic [47:0] potential;
        logic [11:0] best_node;
        logic [47:0] best_potential;
        logic        done;
    } t_node_score;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [3:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // node_index, joint_index, com_x, com_y, com_z, rest_x, rest_y, rest_z, joint_mass
    logic [ppa_pkg::IN_W-1:0]  s_axis_tdata = '0;
    // start_scan
    logic                      s_axis_tuser = 1'b0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // scored_node, node_potential, best_index, best_potential
    logic [ppa_pkg::OUT_W-1:0] m_axis_tdata;
    logic                      m_axis_tlast;

    push_potential_argmax u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state and register copies
    logic [1:0]  cfg_mode = ppa_pkg::MODE_X;
    longint      cfg_contact_x = 0;
    longint      cfg_contact_y = 0;
    longint      cfg_contact_z = 0;
    longint      node_acc = 0;
    longint      best_acc = BEST_FLOOR;
    logic [11:0] best_idx = '0;

    t_joint_word joint_q[$];
    t_node_score score_q[$];
    t_joint_word drv_word;
    t_joint_word node_words[10];
    int          pending_in = 0;
    int          queued_count = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          in_style = 0;
    int          out_style = 0;
    int          in_gap = 0;
    int          ready_wait = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'(v[2*i+1 -: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end else begin
                root = root << 1;
            end
        end
        return 64'(root);
    endfunction

    function automatic longint push_term(input longint d, input logic [23:0] mass);
        longint unsigned prod;
        prod = ((mag64(d) * 64'(mass)) >> 16) * 64'(ppa_pkg::PUSH_WEIGHT);
        return (d < 0) ? -$signed(prod) : $signed(prod);
    endfunction

    function automatic longint rest_term(input longint dx, input longint dy,
                                         input longint dz, input logic [23:0] mass);
        logic [65:0]     ssq;
        longint unsigned root_len;
        ssq = 66'(mag64(dx)) * 66'(mag64(dx)) + 66'(mag64(dy)) * 66'(mag64(dy))
            + 66'(mag64(dz)) * 66'(mag64(dz));
        root_len = floor_sqrt(ssq);
        return -$signed((root_len * 64'(mass)) >> 16);
    endfunction

    // folds one accepted joint word into the node sum and the running best
    function automatic void score_joint(input t_joint_word w);
        longint      term;
        t_node_score r;
        if (w.joint >= ppa_pkg::JOINT_COUNT) return;
        if (w.start) begin
            node_acc = 0;
            best_acc = BEST_FLOOR;
            best_idx = '0;
        end
        if (w.joint >= ppa_pkg::PUSH_FIRST && w.joint <= ppa_pkg::PUSH_LAST) begin
            case (cfg_mode)
                ppa_pkg::MODE_X: term = push_term(longint'(w.com_x) - cfg_contact_x, w.mass);
                ppa_pkg::MODE_Y: term = -push_term(longint'(w.com_y) - cfg_contact_y, w.mass);
                ppa_pkg::MODE_Z: term = push_term(longint'(w.com_z) - cfg_contact_z, w.mass);
                default: term = 0;
            endcase
        end else begin
            term = rest_term(longint'(w.rest_x) - longint'(w.com_x),
                             longint'(w.rest_y) - longint'(w.com_y),
                             longint'(w.rest_z) - longint'(w.com_z), w.mass);
        end
        node_acc = node_acc + term;
        if (node_acc > SUM_TOP) node_acc = SUM_TOP;
        else if (node_acc < SUM_BOTTOM) node_acc = SUM_BOTTOM;
        if (w.joint != ppa_pkg::JOINT_COUNT - 1) return;
        if (node_acc > best_acc) begin
            best_acc = node_acc;
            best_idx = w.node;
        end
        r.node = w.node;
        r.potential = node_acc[47:0];
        r.best_node = best_idx;
        r.best_potential = best_acc[47:0];
        r.done = w.last;
        score_q = {score_q, r};
        node_acc = 0;
    endfunction

    function automatic int draw_gap(input int style);
        case (style)
            0: return 0;
            1: return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 24'h01_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_joint_word make_word(input logic [11:0] node, input logic [3:0] joint,
                                              input logic start, input logic last);
        t_joint_word w;
        w.node = node;
        w.joint = joint;
        w.com_x = rand_coord();
        w.com_y = rand_coord();
        w.com_z = rand_coord();
        w.rest_x = rand_coord();
        w.rest_y = rand_coord();
        w.rest_z = rand_coord();
        w.mass = rand_mass();
        w.start = start;
        w.last = last;
        return w;
    endfunction

    task automatic queue_joint(input t_joint_word w);
        joint_q = {joint_q, w};
        pending_in++;
        if (w.joint < ppa_pkg::JOINT_COUNT) queued_count++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ppa_pkg::REG_MODE:      cfg_mode = value[1:0];
            ppa_pkg::REG_CONTACT_X: cfg_contact_x = longint'($signed(value));
            ppa_pkg::REG_CONTACT_Y: cfg_contact_y = longint'($signed(value));
            default:                cfg_contact_z = longint'($signed(value));
        endcase
    endtask

    task automatic drain();
        while (pending_in != 0 || score_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic directed_words();
        t_joint_word w;
        // zero mass nodes tie at zero, first one stays best
        w = make_word(12'd5, 4'd9, 1'b1, 1'b0);
        w.mass = '0;
        queue_joint(w);
        w = make_word(12'd6, 4'd9, 1'b0, 1'b0);
        w.mass = '0;
        queue_joint(w);
        w = make_word(12'hFFF, 4'd5, 1'b0, 1'b0);
        w.com_x = 32'h7FFF_FFFF;
        w.mass = '1;
        queue_joint(w);
        w = make_word(12'hFFF, 4'd9, 1'b0, 1'b1);
        w.mass = '0;
        queue_joint(w);
        // out of range joints with start set are dropped
        w = make_word(12'd1, 4'd10, 1'b1, 1'b0);
        w.com_x = '1;
        w.mass = '1;
        queue_joint(w);
        w = make_word(12'd2, 4'd15, 1'b1, 1'b1);
        w.mass = '1;
        queue_joint(w);
        // node far below the best floor
        w = make_word(12'd0, 4'd9, 1'b1, 1'b0);
        w.rest_x = 32'h7FFF_FFFF;
        w.rest_y = 32'h7FFF_FFFF;
        w.rest_z = 32'h7FFF_FFFF;
        w.com_x = 32'h8000_0000;
        w.com_y = 32'h8000_0000;
        w.com_z = 32'h8000_0000;
        w.mass = '1;
        queue_joint(w);
        w = make_word(12'd3, 4'd6, 1'b0, 1'b0);
        w.com_x = 32'h8000_0000;
        w.mass = '1;
        queue_joint(w);
        w = make_word(12'd3, 4'd7, 1'b0, 1'b0);
        w.com_x = '0;
        w.mass = '1;
        queue_joint(w);
        w = make_word(12'd3, 4'd0, 1'b0, 1'b0);
        w.rest_x = 32'h8000_0000;
        w.com_x = 32'h7FFF_FFFF;
        w.mass = 24'd1;
        queue_joint(w);
        w = make_word(12'd3, 4'd4, 1'b0, 1'b0);
        w.rest_x = w.com_x;
        w.rest_y = w.com_y;
        w.rest_z = w.com_z;
        w.mass = '1;
        queue_joint(w);
        queue_joint(make_word(12'd3, 4'd8, 1'b0, 1'b0));
        // start and last on the same word, start drops the partial sum
        w = make_word(12'h800, 4'd9, 1'b1, 1'b1);
        w.mass = '0;
        queue_joint(w);
        for (int j = 0; j < ppa_pkg::JOINT_COUNT; j++)
            queue_joint(make_word(12'hABC, 4'(j), 1'b0, 1'b0));
    endtask

    task automatic random_phase(input int quota);
        t_joint_word w;
        int          stop;
        int          nodes;
        int          pick;
        logic        neg;
        logic [11:0] idx;
        stop = queued_count + quota;
        while (queued_count < stop) begin
            pick = $urandom_range(0, 19);
            idx = 12'($urandom);
            if (pick < 2) begin
                queue_joint(make_word(idx, 4'($urandom), 1'($urandom), 1'($urandom)));
            end else if (pick == 2) begin
                // long push run toward saturation
                neg = 1'($urandom);
                for (int k = 0; k < 30; k++) begin
                    w = make_word(idx, 4'($urandom_range(ppa_pkg::PUSH_FIRST,
                                                         ppa_pkg::PUSH_LAST)), 1'b0, 1'b0);
                    w.com_x = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    w.com_y = w.com_x;
                    w.com_z = w.com_x;
                    w.mass = '1;
                    queue_joint(w);
                end
                queue_joint(make_word(idx, 4'(ppa_pkg::JOINT_COUNT - 1), 1'b0, 1'($urandom)));
            end else begin
                nodes = $urandom_range(1, 6);
                for (int n = 0; n < nodes; n++) begin
                    idx = 12'($urandom);
                    // sometimes repeat the previous node to force a tie
                    if (n == 0 || $urandom_range(0, 3) != 0)
                        for (int j = 0; j < ppa_pkg::JOINT_COUNT; j++)
                            node_words[j] = make_word(idx, 4'(j), 1'b0, 1'b0);
                    for (int j = 0; j < ppa_pkg::JOINT_COUNT; j++) begin
                        w = node_words[j];
                        w.node = idx;
                        w.start = (n == 0 && j == 0 && $urandom_range(0, 3) != 0);
                        w.last = (n == nodes - 1);
                        if ($urandom_range(0, 24) != 0) queue_joint(w);
                    end
                end
            end
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (in_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                in_gap--;
            end else if (joint_q.size() != 0) begin
                drv_word = joint_q.pop_front();
                s_axis_tdata <= {drv_word.mass, drv_word.rest_z, drv_word.rest_y,
                                 drv_word.rest_x, drv_word.com_z, drv_word.com_y,
                                 drv_word.com_x, drv_word.joint, drv_word.node};
                s_axis_tuser <= drv_word.start;
                s_axis_tlast <= drv_word.last;
                s_axis_tvalid <= 1'b1;
                in_gap = draw_gap(in_style);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) ready_wait = draw_gap(out_style);
            if (ready_wait != 0) begin
                m_axis_tready <= 1'b0;
                ready_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_node_score want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                score_joint(drv_word);
                pending_in--;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (score_q.size() == 0) begin
                    report_mismatch("word with nothing expected", 64'(m_axis_tdata), '0);
                end else begin
                    want = score_q.pop_front();
                    if (m_axis_tdata[11:0] !== want.node)
                        report_mismatch("scored_node", 64'(m_axis_tdata[11:0]), 64'(want.node));
                    if (m_axis_tdata[59:12] !== want.potential)
                        report_mismatch("node_potential", 64'(m_axis_tdata[59:12]),
                                        64'(want.potential));
                    if (m_axis_tdata[71:60] !== want.best_node)
                        report_mismatch("best_index", 64'(m_axis_tdata[71:60]),
                                        64'(want.best_node));
                    if (m_axis_tdata[119:72] !== want.best_potential)
                        report_mismatch("best_potential", 64'(m_axis_tdata[119:72]),
                                        64'(want.best_potential));
                    if (m_axis_tlast !== want.done)
                        report_mismatch("scan_done", 64'(m_axis_tlast), 64'(want.done));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int phase = 0; phase < 8; phase++) begin
            in_style = phase % 3;
            out_style = (phase + 1) % 3;
            if (phase == 0) begin
                directed_words();
            end else begin
                drain();
                case (phase)
                    1: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_Y));
                    2: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_Z));
                    3: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_OFF));
                    4: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_X));
                    5: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_Y));
                    6: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_Z));
                    default: apb_write(ppa_pkg::REG_MODE, 32'(ppa_pkg::MODE_X));
                endcase
                case (phase)
                    1: begin
                        apb_write(ppa_pkg::REG_CONTACT_X, 32'h7FFF_FFFF);
                        apb_write(ppa_pkg::REG_CONTACT_Y, 32'h7FFF_FFFF);
                        apb_write(ppa_pkg::REG_CONTACT_Z, 32'h7FFF_FFFF);
                    end
                    2: begin
                        apb_write(ppa_pkg::REG_CONTACT_X, 32'h8000_0000);
                        apb_write(ppa_pkg::REG_CONTACT_Y, 32'h8000_0000);
                        apb_write(ppa_pkg::REG_CONTACT_Z, 32'h8000_0000);
                    end
                    7: begin
                        apb_write(ppa_pkg::REG_CONTACT_X, '0);
                        apb_write(ppa_pkg::REG_CONTACT_Y, '0);
                        apb_write(ppa_pkg::REG_CONTACT_Z, '0);
                    end
                    default: begin
                        apb_write(ppa_pkg::REG_CONTACT_X, rand_coord());
                        apb_write(ppa_pkg::REG_CONTACT_Y, rand_coord());
                        apb_write(ppa_pkg::REG_CONTACT_Z, rand_coord());
                    end
                endcase
            end
            random_phase(PHASE_WORDS);
        end
        drain();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/ppa_pkg.sv
rtl/ppa_ctrl.sv
rtl/ppa_dp.sv
rtl/push_potential_argmax.sv
rtl/ppa_chk.sv
tb/tb_push_potential_argmax.sv
